// ===== src/crm_pkg.sv =====
package crm_pkg;

   localparam int StampSlots = 16;

   localparam int ReqW   = 48;
   localparam int RspW   = 40;
   localparam int PressW = 16;
   localparam int TimeW  = 32;
   localparam int LifeW  = 16;
   localparam int RateW  = 16;
   localparam int CsrW   = 32;

   localparam logic [LifeW-1:0] MsPerMinute  = 16'd60000;
   localparam logic [LifeW-1:0] LifeReset    = 16'd10000;
   localparam logic [16:0]      ReleaseMul   = 17'd52429;
   localparam int               ReleaseShift = 19;
   localparam logic [RateW-1:0] LowRate      = 16'd80;
   localparam logic [1:0]       DotTop       = 2'd3;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_RATE = 2'd1,
      ACT_DOT  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CSR_ENABLE    = 2'd0,
      CSR_THRESHOLD = 2'd1,
      CSR_REFRESH   = 2'd2,
      CSR_LIFE      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             start;
      logic [LifeW-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic             busy;
      logic [LifeW-1:0] quotient;
   } div_stat_type;

endpackage

// ===== src/crm_divider.sv =====
module crm_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  crm_pkg::div_ctrl_type ctrl,
   output crm_pkg::div_stat_type stat
);
   import crm_pkg::*;

   localparam int Steps = LifeW;
   localparam int StepW = $clog2(Steps);

   logic             busy_ff, busy_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [LifeW-1:0] rem_ff, rem_in;
   logic [LifeW-1:0] quot_ff, quot_in;
   logic [LifeW-1:0] divisor_ff, divisor_in;
   logic [LifeW:0]   trial;
   logic [LifeW:0]   diff;
   logic             fits;

   always_comb begin
      trial      = {rem_ff, quot_ff[LifeW-1]};
      diff       = trial - {1'b0, divisor_ff};
      fits       = trial >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (ctrl.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         quot_in    = MsPerMinute;
         divisor_in = ctrl.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[LifeW-1:0] : trial[LifeW-1:0];
         quot_in = {quot_ff[LifeW-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == StepW'(Steps - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.quotient = quot_ff;

endmodule

// ===== src/crm_stamp_store.sv =====
module crm_stamp_store #(
   parameter int Slots = crm_pkg::StampSlots,
   parameter int SlotW = (Slots > 1) ? $clog2(Slots) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [SlotW-1:0]         wr_addr,
   input  logic [crm_pkg::TimeW-1:0] wr_data,
   input  logic [SlotW-1:0]         rd_addr,
   output logic [crm_pkg::TimeW-1:0] rd_data
);
   import crm_pkg::*;

   logic [TimeW-1:0] mem [Slots];
   logic [TimeW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/compression_rate_meter.sv =====
// Press-rate meter for a pressure sensor stream. Each sample transaction carries a
// pressure reading and the current millisecond time, and exactly one result
// transaction comes back for it. An enabled sample that does not trigger a rate
// evaluation passes from the press check state to the hold state, and a sample
// taken while the block is disabled goes straight to the hold state. A sample that
// triggers an evaluation walks the time stamp ring one slot per cycle through a
// single age comparator and the single read port of the stamp memory, which holds
// sixteen slots by default. The factor 60000 / data_life comes from a bit-serial
// divider that runs after reset and after every write of data_life; req_tready
// stays low while it runs. The result sits in an output register, so a sample
// can be accepted while the previous result still waits for rsp_tready.
module compression_rate_meter #(
   parameter int STAMP_SLOTS = crm_pkg::StampSlots
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // Fields from bit 0: pressure[15:0], now_ms[31:0].
   input  logic [crm_pkg::ReqW-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // Fields from bit 0: display_action[1:0], rate_value[15:0], dot_index[1:0],
   // pressure_out[15:0], then four zero bits.
   output logic [crm_pkg::RspW-1:0] rsp_tdata,
   input  logic                     csr_we,
   input  logic [1:0]               csr_addr,
   input  logic [crm_pkg::CsrW-1:0] csr_wdata
);
   import crm_pkg::*;

   localparam int SlotW = (STAMP_SLOTS > 1) ? $clog2(STAMP_SLOTS) : 1;
   localparam int WalkW = $clog2(STAMP_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRESS,
      ST_WALK,
      ST_FINISH,
      ST_HOLD
   } state_type;

   logic                   enable_ff;
   logic [PressW-1:0]      thr_ff;
   logic [TimeW-1:0]       refresh_ff;
   logic [LifeW-1:0]       life_ff;
   logic                   div_start_ff, div_start_in;

   state_type              state_ff, state_in;
   logic [PressW-1:0]      pressure_ff, pressure_in;
   logic [TimeW-1:0]       now_ff, now_in;
   logic                   pressing_ff, pressing_in;
   logic [SlotW-1:0]       wslot_ff, wslot_in;
   logic [STAMP_SLOTS-1:0] valid_ff, valid_in;
   logic                   started_ff, started_in;
   logic [TimeW-1:0]       start_time_ff, start_time_in;
   logic [TimeW-1:0]       last_eval_ff, last_eval_in;
   logic [1:0]             dot_ff, dot_in;
   logic [WalkW-1:0]       walk_ff, walk_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [SlotW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [WalkW-1:0]       count_ff, count_in;
   action_type             res_action_ff, res_action_in;
   logic [RateW-1:0]       res_rate_ff, res_rate_in;
   logic [1:0]             res_dot_ff, res_dot_in;
   logic [PressW-1:0]      res_press_ff, res_press_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RspW-1:0]        rsp_data_ff, rsp_data_in;

   div_ctrl_type           div_ctrl;
   div_stat_type           div_stat;

   logic                   mem_we;
   logic [TimeW-1:0]       rd_data;

   logic [TimeW-1:0]       age_base;
   logic [TimeW-1:0]       age_limit;
   logic [TimeW-1:0]       age;
   logic                   age_below;

   logic [ReleaseShift+PressW-1:0] rel_prod;
   logic [PressW-1:0]      release_lvl;
   logic                   press_start;
   logic                   issue;
   logic [RateW+WalkW-1:0] rate_full;
   logic [RateW-1:0]       rate;
   logic                   visible;
   logic                   accept;

   crm_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   crm_stamp_store #(
      .Slots (STAMP_SLOTS),
      .SlotW (SlotW)
   ) u_stamp_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wslot_ff),
      .wr_data (now_ff),
      .rd_addr (walk_ff[SlotW-1:0]),
      .rd_data (rd_data)
   );

   assign div_ctrl.start   = div_start_ff;
   assign div_ctrl.divisor = life_ff;
   assign div_start_in     = csr_we && (csr_index_type'(csr_addr) == CSR_LIFE);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         thr_ff       <= '0;
         refresh_ff   <= '0;
         life_ff      <= LifeReset;
         div_start_ff <= 1'b1;
      end else begin
         div_start_ff <= div_start_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_addr))
               CSR_ENABLE:    enable_ff  <= csr_wdata[0];
               CSR_THRESHOLD: thr_ff     <= csr_wdata[PressW-1:0];
               CSR_REFRESH:   refresh_ff <= csr_wdata[TimeW-1:0];
               CSR_LIFE:      life_ff    <= csr_wdata[LifeW-1:0];
            endcase
         end
      end
   end

   // One age comparator serves the refresh check, every stamp and the start time.
   always_comb begin
      unique case (state_ff)
         ST_PRESS: begin
            age_base  = last_eval_ff;
            age_limit = refresh_ff;
         end
         ST_WALK: begin
            age_base  = rd_data;
            age_limit = {{(TimeW-LifeW){1'b0}}, life_ff};
         end
         default: begin
            age_base  = start_time_ff;
            age_limit = {{(TimeW-LifeW){1'b0}}, life_ff};
         end
      endcase
      age       = now_ff - age_base;
      age_below = age < age_limit;
   end

   assign rel_prod    = thr_ff * ReleaseMul;
   assign release_lvl = rel_prod[ReleaseShift +: PressW];
   assign press_start = (pressure_ff > thr_ff) && !pressing_ff;
   assign mem_we      = (state_ff == ST_PRESS) && press_start;
   assign issue       = walk_ff != WalkW'(STAMP_SLOTS);
   assign rate_full   = div_stat.quotient * count_ff;
   assign rate        = (life_ff == '0) ? '0 : rate_full[RateW-1:0];
   assign visible     = (rate >= LowRate) || !age_below;

   assign req_tready = (state_ff == ST_IDLE) && !div_stat.busy && !div_start_ff
                       && !div_start_in;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      pressure_in   = pressure_ff;
      now_in        = now_ff;
      pressing_in   = pressing_ff;
      wslot_in      = wslot_ff;
      valid_in      = valid_ff;
      started_in    = started_ff;
      start_time_in = start_time_ff;
      last_eval_in  = last_eval_ff;
      dot_in        = dot_ff;
      walk_in       = walk_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      count_in      = count_ff;
      res_action_in = res_action_ff;
      res_rate_in   = res_rate_ff;
      res_dot_in    = res_dot_ff;
      res_press_in  = res_press_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pressure_in = req_tdata[PressW-1:0];
               now_in      = req_tdata[PressW +: TimeW];
               if (enable_ff) begin
                  state_in = ST_PRESS;
               end else begin
                  res_action_in = ACT_NONE;
                  res_rate_in   = '0;
                  res_dot_in    = '0;
                  res_press_in  = '0;
                  state_in      = ST_HOLD;
               end
            end
         end
         ST_PRESS: begin
            if (press_start) begin
               valid_in    = valid_ff | (STAMP_SLOTS'(1) << wslot_ff);
               wslot_in    = (wslot_ff == SlotW'(STAMP_SLOTS - 1)) ? '0 : wslot_ff + 1'b1;
               pressing_in = 1'b1;
            end else if (pressure_ff <= release_lvl) begin
               pressing_in = 1'b0;
            end
            started_in = valid_in[0];
            if (valid_in[0] && !started_ff) begin
               start_time_in = now_ff;
            end
            res_press_in = pressure_ff;
            if (valid_in[0] && !age_below) begin
               last_eval_in = now_ff;
               walk_in      = '0;
               count_in     = '0;
               state_in     = ST_WALK;
            end else begin
               res_action_in = ACT_NONE;
               res_rate_in   = '0;
               res_dot_in    = '0;
               state_in      = ST_HOLD;
            end
         end
         ST_WALK: begin
            if (issue) begin
               walk_in      = walk_ff + 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = walk_ff[SlotW-1:0];
            end else begin
               state_in = ST_FINISH;
            end
            if (cmp_valid_ff && valid_ff[cmp_idx_ff] && age_below) begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (visible) begin
               res_action_in = ACT_RATE;
               res_rate_in   = rate;
               res_dot_in    = '0;
            end else begin
               res_action_in = ACT_DOT;
               res_rate_in   = '0;
               res_dot_in    = dot_ff;
               dot_in        = (dot_ff == '0) ? DotTop : dot_ff - 1'b1;
            end
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, res_press_ff, res_dot_ff, res_rate_ff, res_action_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pressing_ff  <= 1'b0;
         wslot_ff     <= '0;
         valid_ff     <= '0;
         started_ff   <= 1'b0;
         last_eval_ff <= '0;
         start_time_ff <= '0;
         dot_ff       <= DotTop;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pressing_ff   <= pressing_in;
         wslot_ff      <= wslot_in;
         valid_ff      <= valid_in;
         started_ff    <= started_in;
         last_eval_ff  <= last_eval_in;
         start_time_ff <= start_time_in;
         dot_ff        <= dot_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pressure_ff   <= pressure_in;
      now_ff        <= now_in;
      walk_ff       <= walk_in;
      cmp_idx_ff    <= cmp_idx_in;
      count_ff      <= count_in;
      res_action_ff <= res_action_in;
      res_rate_ff   <= res_rate_in;
      res_dot_ff    <= res_dot_in;
      res_press_ff  <= res_press_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_ready_needs_quotient: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_stat.busy)
      else $error("Sample accepted while the divider is still running.");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
      else $error("Sequencer stayed idle after a sample transaction.");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (count_ff <= WalkW'(STAMP_SLOTS)))
      else $error("Stamp count exceeds the ring size.");

   a_dot_has_no_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == ACT_DOT)) |-> (rsp_tdata[17:2] == '0))
      else $error("Loading dot result carries a nonzero rate.");
`endif

endmodule
